// ===== rtl/tpc_pkg.sv =====
// Package for the touch point calibrator.
// Holds widths, register indexes, reset values and the divider cell types.
// Used by every file under rtl.
package tpc_pkg;

  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned RAW_W   = 12;
  localparam int unsigned PTS_W   = 4;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned PROD_W  = 45;
  localparam int unsigned NUM_W   = 47;
  localparam int unsigned REM_W   = 47;
  localparam int unsigned DVS_W   = 32;
  localparam int unsigned QUO_W   = 13;
  localparam int unsigned RES_W   = 16;
  localparam int unsigned DEF_SCREEN = 240;

  localparam logic [CFG_W-1:0] RST_OFFSET = 32'd0;
  localparam logic [CFG_W-1:0] RST_SCALE  = 32'd65536;
  localparam logic [CFG_W-2:0] RST_DIVISOR = 31'd65536;

  typedef enum logic [IDX_W-1:0] {
    IDX_OFFSET_X = 3'd0,
    IDX_SCALE_X  = 3'd1,
    IDX_SHEAR_XY = 3'd2,
    IDX_OFFSET_Y = 3'd3,
    IDX_SHEAR_YX = 3'd4,
    IDX_SCALE_Y  = 3'd5,
    IDX_DIVISOR  = 3'd6,
    IDX_NONE     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    logic  valid;
    logic  press;
    logic  act;
    lane_t x;
    lane_t y;
  } cell_t;

endpackage

// ===== rtl/tpc_div_cell.sv =====
// One restoring division step for both axes of the calibrator.
// Depends on tpc_pkg for the cell and lane types.
module tpc_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [tpc_pkg::DVS_W-1:0]      dvs_i,
  input  tpc_pkg::cell_t                 in_i,
  output tpc_pkg::cell_t                 out_o
);

  logic [tpc_pkg::REM_W-1:0] trial;
  tpc_pkg::cell_t            cell_d, cell_q;

  assign trial = {{(tpc_pkg::REM_W-tpc_pkg::DVS_W){1'b0}}, dvs_i} << SHIFT;

  always_comb begin
    cell_d = in_i;
    if (in_i.x.rem >= trial) begin
      cell_d.x.rem        = in_i.x.rem - trial;
      cell_d.x.quo[SHIFT] = 1'b1;
    end
    if (in_i.y.rem >= trial) begin
      cell_d.y.rem        = in_i.y.rem - trial;
      cell_d.y.quo[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

// ===== rtl/tpc_post.sv =====
// Rounding sign, edge correction and screen clamp for one axis.
// Depends on tpc_pkg for the lane type and widths.
module tpc_post #(
  parameter int unsigned LIMIT = tpc_pkg::DEF_SCREEN
) (
  input  tpc_pkg::lane_t              lane_i,
  output logic [tpc_pkg::PIX_W-1:0]   pix_o
);

  localparam logic signed [tpc_pkg::RES_W-1:0] MAX_PIX = tpc_pkg::RES_W'(LIMIT - 1);
  localparam logic signed [tpc_pkg::RES_W-1:0] EDGE    = 16'sd120;

  logic [tpc_pkg::QUO_W:0]           mag;
  logic signed [tpc_pkg::RES_W-1:0]  r, r2, gap;
  logic [29:0]                       prod;

  always_comb begin
    mag  = lane_i.ovf ? {1'b1, {tpc_pkg::QUO_W{1'b0}}} : {1'b0, lane_i.quo};
    r    = lane_i.neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    gap  = EDGE - r;
    prod = 30'(gap[14:0]) * 30'd10923;
    r2   = r;
    if (r < EDGE) begin
      r2 = r + $signed({2'b00, prod[29:16]});
    end
    if (r2 < 0) begin
      pix_o = '0;
    end else if (r2 > MAX_PIX) begin
      pix_o = MAX_PIX[tpc_pkg::PIX_W-1:0];
    end else begin
      pix_o = r2[tpc_pkg::PIX_W-1:0];
    end
  end

endmodule

// ===== rtl/touch_point_calibrator.sv =====
// Touch point calibrator top level: config registers, multiply front end,
// divider cell chain and output register.
// Depends on tpc_pkg, tpc_div_cell and tpc_post.
//
// Usage: pulse start_i with one raw sample; busy_o stays low, so a sample
// transfers at every edge where start_i is high, one per cycle sustained.
// Each sample gives exactly one result, shown for one cycle with done_o high
// once it has passed the registered stages in order: two front stages
// (products, then the sum and rounding offset), 13 divider cells, one for
// each quotient bit, and the output register.
// The receiver cannot stall; results are dropped if not taken that cycle.
// Configuration writes through cfg_we_i/cfg_idx_i/cfg_wdata_i take effect at
// once; write only while no sample is in flight. Index 7 is ignored.
// Reset clears the pipeline (all but the product registers) and loads identity
// calibration (scale 1.0, divisor 1.0, offsets and shears 0).
module touch_point_calibrator #(
  parameter int unsigned SCREEN_WIDTH  = tpc_pkg::DEF_SCREEN,
  parameter int unsigned SCREEN_HEIGHT = tpc_pkg::DEF_SCREEN
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [tpc_pkg::PTS_W-1:0]     touch_points_i,
  input  logic [tpc_pkg::RAW_W-1:0]     raw_x_i,
  input  logic [tpc_pkg::RAW_W-1:0]     raw_y_i,
  input  logic                          calibration_active_i,
  input  logic                          ignore_touch_i,
  input  logic                          cfg_we_i,
  input  logic [tpc_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [tpc_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                          done_o,
  output logic                          pressed_o,
  output logic [tpc_pkg::PIX_W-1:0]     point_x_o,
  output logic [tpc_pkg::PIX_W-1:0]     point_y_o,
  output logic                          activity_seen_o
);

  localparam int unsigned LATENCY = tpc_pkg::QUO_W + 3;

  logic signed [tpc_pkg::CFG_W-1:0] off_x_q, scl_x_q, shr_xy_q, off_y_q, shr_yx_q, scl_y_q;
  logic [tpc_pkg::CFG_W-2:0]        dvs_q, dvs_eff;
  logic [tpc_pkg::DVS_W-1:0]        dvs2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q  <= tpc_pkg::RST_OFFSET;
      scl_x_q  <= tpc_pkg::RST_SCALE;
      shr_xy_q <= tpc_pkg::RST_OFFSET;
      off_y_q  <= tpc_pkg::RST_OFFSET;
      shr_yx_q <= tpc_pkg::RST_OFFSET;
      scl_y_q  <= tpc_pkg::RST_SCALE;
      dvs_q    <= tpc_pkg::RST_DIVISOR;
    end else if (cfg_we_i) begin
      case (tpc_pkg::cfg_idx_e'(cfg_idx_i))
        tpc_pkg::IDX_OFFSET_X: off_x_q  <= cfg_wdata_i;
        tpc_pkg::IDX_SCALE_X:  scl_x_q  <= cfg_wdata_i;
        tpc_pkg::IDX_SHEAR_XY: shr_xy_q <= cfg_wdata_i;
        tpc_pkg::IDX_OFFSET_Y: off_y_q  <= cfg_wdata_i;
        tpc_pkg::IDX_SHEAR_YX: shr_yx_q <= cfg_wdata_i;
        tpc_pkg::IDX_SCALE_Y:  scl_y_q  <= cfg_wdata_i;
        tpc_pkg::IDX_DIVISOR:  dvs_q    <= cfg_wdata_i[tpc_pkg::CFG_W-2:0];
        default: ;
      endcase
    end
  end

  assign dvs_eff = (dvs_q == '0) ? 31'd1 : dvs_q;
  assign dvs2    = {dvs_eff, 1'b0};
  assign busy_o  = 1'b0;

  // Stage one: products
  logic                              s1_valid_q, s1_press_q, s1_act_q;
  logic signed [tpc_pkg::PROD_W-1:0] p_xa_q, p_xb_q, p_ya_q, p_yb_q;
  logic signed [tpc_pkg::RAW_W:0]    rx_s, ry_s;

  assign rx_s = $signed({1'b0, raw_x_i});
  assign ry_s = $signed({1'b0, raw_y_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_press_q <= 1'b0;
      s1_act_q   <= 1'b0;
    end else begin
      s1_valid_q <= start_i & ~busy_o;
      s1_press_q <= (touch_points_i != '0) & ~calibration_active_i & ~ignore_touch_i;
      s1_act_q   <= (touch_points_i != '0) & ~calibration_active_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_xa_q <= scl_x_q  * rx_s;
    p_xb_q <= shr_xy_q * ry_s;
    p_ya_q <= shr_yx_q * rx_s;
    p_yb_q <= scl_y_q  * ry_s;
  end

  // Stage two: sum, rounding offset, magnitude and range check
  function automatic tpc_pkg::lane_t make_lane(
    input logic signed [tpc_pkg::PROD_W-1:0] pa,
    input logic signed [tpc_pkg::PROD_W-1:0] pb,
    input logic signed [tpc_pkg::CFG_W-1:0]  off,
    input logic [tpc_pkg::CFG_W-2:0]         dv,
    input logic [tpc_pkg::DVS_W-1:0]         dv2
  );
    logic signed [tpc_pkg::NUM_W-1:0] num;
    logic signed [tpc_pkg::NUM_W:0]   n2;
    logic [tpc_pkg::NUM_W:0]          mag;
    tpc_pkg::lane_t                   ln;
    num = tpc_pkg::NUM_W'(pa) + tpc_pkg::NUM_W'(pb) + tpc_pkg::NUM_W'(off);
    n2  = $signed({num, 1'b0}) + $signed({17'd0, dv});
    mag = n2[tpc_pkg::NUM_W] ? -n2 : n2;
    ln.rem = mag[tpc_pkg::REM_W-1:0];
    ln.quo = '0;
    ln.neg = n2[tpc_pkg::NUM_W];
    ln.ovf = mag[tpc_pkg::REM_W-1:0] >=
             ({{(tpc_pkg::REM_W-tpc_pkg::DVS_W){1'b0}}, dv2} << tpc_pkg::QUO_W);
    return ln;
  endfunction

  tpc_pkg::cell_t chain [tpc_pkg::QUO_W+1];
  tpc_pkg::cell_t s2_d, s2_q;

  always_comb begin
    s2_d.valid = s1_valid_q;
    s2_d.press = s1_press_q;
    s2_d.act   = s1_act_q;
    s2_d.x     = make_lane(p_xa_q, p_xb_q, off_x_q, dvs_eff, dvs2);
    s2_d.y     = make_lane(p_ya_q, p_yb_q, off_y_q, dvs_eff, dvs2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else begin
      s2_q <= s2_d;
    end
  end

  assign chain[0] = s2_q;

  for (genvar k = 0; k < tpc_pkg::QUO_W; k++) begin : g_cell
    tpc_div_cell #(
      .SHIFT(tpc_pkg::QUO_W - 1 - k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .dvs_i (dvs2),
      .in_i  (chain[k]),
      .out_o (chain[k+1])
    );
  end

  logic [tpc_pkg::PIX_W-1:0] pix_x, pix_y;

  tpc_post #(.LIMIT(SCREEN_WIDTH))  u_post_x (.lane_i(chain[tpc_pkg::QUO_W].x), .pix_o(pix_x));
  tpc_post #(.LIMIT(SCREEN_HEIGHT)) u_post_y (.lane_i(chain[tpc_pkg::QUO_W].y), .pix_o(pix_y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o          <= 1'b0;
      pressed_o       <= 1'b0;
      point_x_o       <= '0;
      point_y_o       <= '0;
      activity_seen_o <= 1'b0;
    end else begin
      done_o          <= chain[tpc_pkg::QUO_W].valid;
      pressed_o       <= chain[tpc_pkg::QUO_W].press;
      activity_seen_o <= chain[tpc_pkg::QUO_W].act;
      point_x_o       <= chain[tpc_pkg::QUO_W].press ? pix_x : '0;
      point_y_o       <= chain[tpc_pkg::QUO_W].press ? pix_y : '0;
    end
  end

  a_press_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pressed_o |-> activity_seen_o) else $error("press without activity");

  a_release_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pressed_o |-> (point_x_o == '0 && point_y_o == '0)) else $error("released point not zero");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o) else $error("result missing");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(point_x_o) <= SCREEN_WIDTH - 1 && 32'(point_y_o) <= SCREEN_HEIGHT - 1))
    else $error("point off screen");

endmodule
